@@ sv/bsa_pkg.sv @@
// bsa_pkg: shared constants, codes and structs of the bitmap slot allocator
// used by the channel interfaces, the front queue, the back engine and the top level
`default_nettype none
package bsa_pkg;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned BIT_W      = 6;
  localparam int unsigned MAP_WORDS  = 512;
  localparam int unsigned WADDR_W    = 9;
  localparam int unsigned SLOT_W     = 15;
  localparam int unsigned TOTAL_SLOTS = MAP_WORDS * WORD_W;
  localparam int unsigned INIT_SLOTS = 4096;
  localparam int unsigned MAX_RUN    = 64;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned EXT_W      = 2 * WORD_W;
  localparam int unsigned EXT_IDX_W  = 8;
  localparam int unsigned LVLS       = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_BAD   = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREE_START = 2'd0,
    CFG_FREE_END   = 2'd1
  } cfg_idx_e;

  // what the back engine has to do with a request
  typedef enum logic [2:0] {
    K_INIT,
    K_ALLOC,
    K_FREE,
    K_NOP,
    K_FAIL
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_ALLOC,
    ST_MARK,
    ST_MARK2,
    ST_FREE_RD,
    ST_FREE_WR
  } back_state_e;

  typedef struct packed {
    kind_e             kind;
    logic [CNT_W-1:0]  count;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } front_out_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;
endpackage
`default_nettype wire

@@ sv/bsa_if.sv @@
// bsa channel interfaces: request, response and register write channels
// depends on bsa_pkg for field widths
`default_nettype none
interface bsa_req_if;
  logic                         valid;
  logic                         ready;
  logic [bsa_pkg::OP_W-1:0]     op;
  logic [bsa_pkg::CNT_W-1:0]    count;
  logic [bsa_pkg::SLOT_W-1:0]   slot_index;
  modport source (output valid, op, count, slot_index, input ready);
  modport sink (input valid, op, count, slot_index, output ready);
endinterface

interface bsa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic [bsa_pkg::SLOT_W-1:0] first_slot;
  modport source (output valid, status, first_slot, input ready);
  modport sink (input valid, status, first_slot, output ready);
endinterface

interface bsa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bsa_pkg::CFG_IDX_W-1:0] index;
  logic [bsa_pkg::CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/bsa_front.sv @@
// bsa_front: accepts requests, classifies them and holds them in a two-entry queue
// depends on bsa_pkg and bsa_req_if
`default_nettype none
module bsa_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  bsa_req_if.sink               req,
  input  bsa_pkg::back_stat_t   stat_i,
  output bsa_pkg::front_out_t   fout_o
);
  bsa_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    fill_q, fill_d;
  logic          push;
  bsa_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.count = req.count;
    cmd_in.slot  = req.slot_index;
    case (bsa_pkg::op_e'(req.op))
      bsa_pkg::OP_INIT: cmd_in.kind = bsa_pkg::K_INIT;
      bsa_pkg::OP_ALLOC: begin
        if (req.count == '0 || 32'(req.count) > bsa_pkg::MAX_RUN) begin
          cmd_in.kind = bsa_pkg::K_FAIL;
        end else begin
          cmd_in.kind = bsa_pkg::K_ALLOC;
        end
      end
      bsa_pkg::OP_FREE: begin
        if (32'(req.slot_index) < bsa_pkg::TOTAL_SLOTS) begin
          cmd_in.kind = bsa_pkg::K_FREE;
        end else begin
          cmd_in.kind = bsa_pkg::K_NOP;
        end
      end
      default: cmd_in.kind = bsa_pkg::K_FAIL;
    endcase
  end

  assign req.ready = (fill_q != 2'd2) && !stat_i.clearing;
  assign push      = req.valid && req.ready;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ stat_i.pop;
    fill_d   = fill_q + {1'b0, push} - {1'b0, stat_i.pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign fout_o.valid = (fill_q != 2'd0);
  assign fout_o.cmd   = entry_q[rd_ptr_q];
endmodule
`default_nettype wire

@@ sv/bsa_back.sv @@
// bsa_back: bitmap memory and the engine that runs init, allocate and free
// depends on bsa_pkg and bsa_rsp_if
`default_nettype none
module bsa_back (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  bsa_pkg::front_out_t        fout_i,
  input  wire [bsa_pkg::CFG_W-1:0]   free_start_i,
  input  wire [bsa_pkg::CFG_W-1:0]   free_end_i,
  output bsa_pkg::back_stat_t        stat_o,
  bsa_rsp_if.source                  rsp
);
  localparam logic [bsa_pkg::WADDR_W-1:0] LAST_W = bsa_pkg::WADDR_W'(bsa_pkg::MAP_WORDS - 1);

  logic [bsa_pkg::WORD_W-1:0] mem [bsa_pkg::MAP_WORDS];
  logic [bsa_pkg::WORD_W-1:0] rdata_q;
  logic                       we, re;
  logic [bsa_pkg::WADDR_W-1:0] waddr, raddr;
  logic [bsa_pkg::WORD_W-1:0] wdata;

  bsa_pkg::back_state_e state_q, state_d;
  bsa_pkg::cmd_t        cmd_q, cmd_d;
  logic [bsa_pkg::WADDR_W-1:0] rd_w_q, rd_w_d;
  logic                        rd_more_q, rd_more_d;
  logic [bsa_pkg::WADDR_W-1:0] ev_w_q, ev_w_d;
  logic                        ev_vld_q, ev_vld_d;
  logic [bsa_pkg::WORD_W-1:0]  prev_free_q, prev_free_d;
  logic [bsa_pkg::WADDR_W-1:0] hit_w_q, hit_w_d;
  logic [bsa_pkg::EXT_IDX_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [bsa_pkg::EXT_W-1:0]   used_q, used_d;
  logic [bsa_pkg::SLOT_W-1:0]  first_q, first_d;
  logic                        out_vld_q, out_vld_d;
  logic                        out_st_q, out_st_d;
  logic [bsa_pkg::SLOT_W-1:0]  out_first_q, out_first_d;

  logic [bsa_pkg::EXT_W-1:0]   ext, pw, acc, mask;
  logic                        hit;
  logic [bsa_pkg::BIT_W-1:0]   hit_b;
  logic [bsa_pkg::WORD_W-1:0]  init_word;
  logic [bsa_pkg::CFG_W-1:0]   sl;

  // window of count free slots ending at each bit, built by doubling
  always_comb begin
    ext = {~rdata_q, prev_free_q};
    pw  = ext;
    acc = '1;
    for (int k = 0; k < bsa_pkg::LVLS; k++) begin
      if (cmd_q.count[k]) begin
        acc = pw & (acc << (1 << k));
      end
      pw = pw & (pw << (1 << k));
    end
    hit   = |acc[bsa_pkg::EXT_W-1:bsa_pkg::WORD_W];
    hit_b = '0;
    for (int b = bsa_pkg::WORD_W - 1; b >= 0; b--) begin
      if (acc[bsa_pkg::WORD_W + b]) begin
        hit_b = bsa_pkg::BIT_W'(b);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < bsa_pkg::EXT_W; i++) begin
      mask[i] = (bsa_pkg::EXT_IDX_W'(i) >= lo_q) && (bsa_pkg::EXT_IDX_W'(i) <= hi_q);
    end
  end

  always_comb begin
    for (int b = 0; b < bsa_pkg::WORD_W; b++) begin
      sl = {1'b0, ev_w_q, bsa_pkg::BIT_W'(b)};
      if (sl >= free_start_i && sl < free_end_i) begin
        init_word[b] = 1'b0;
      end else if (32'(sl) < bsa_pkg::INIT_SLOTS) begin
        init_word[b] = 1'b1;
      end else begin
        init_word[b] = rdata_q[b];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    rd_w_d      = rd_w_q;
    rd_more_d   = rd_more_q;
    ev_w_d      = ev_w_q;
    ev_vld_d    = 1'b0;
    prev_free_d = prev_free_q;
    hit_w_d     = hit_w_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    used_d      = used_q;
    first_d     = first_q;
    out_vld_d   = out_vld_q && !rsp.ready;
    out_st_d    = out_st_q;
    out_first_d = out_first_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    re          = 1'b0;
    raddr       = rd_w_q;
    stat_o.pop      = 1'b0;
    stat_o.clearing = (state_q == bsa_pkg::ST_CLEAR);

    // scan read stream shared by init and allocate
    if ((state_q == bsa_pkg::ST_INIT || state_q == bsa_pkg::ST_ALLOC) && rd_more_q) begin
      re       = 1'b1;
      ev_vld_d = 1'b1;
      ev_w_d   = rd_w_q;
      rd_w_d   = rd_w_q + 1'b1;
      if (rd_w_q == LAST_W) begin
        rd_more_d = 1'b0;
      end
    end

    case (state_q)
      bsa_pkg::ST_CLEAR: begin
        we     = 1'b1;
        waddr  = rd_w_q;
        rd_w_d = rd_w_q + 1'b1;
        if (rd_w_q == LAST_W) begin
          state_d = bsa_pkg::ST_IDLE;
          rd_w_d  = '0;
        end
      end
      bsa_pkg::ST_IDLE: begin
        if (fout_i.valid && !out_vld_q) begin
          stat_o.pop  = 1'b1;
          cmd_d       = fout_i.cmd;
          rd_w_d      = '0;
          rd_more_d   = 1'b1;
          prev_free_d = '0;
          case (fout_i.cmd.kind)
            bsa_pkg::K_INIT:  state_d = bsa_pkg::ST_INIT;
            bsa_pkg::K_ALLOC: state_d = bsa_pkg::ST_ALLOC;
            bsa_pkg::K_FREE:  state_d = bsa_pkg::ST_FREE_RD;
            bsa_pkg::K_NOP: begin
              out_vld_d   = 1'b1;
              out_st_d    = 1'b0;
              out_first_d = '0;
            end
            default: begin
              out_vld_d   = 1'b1;
              out_st_d    = 1'b1;
              out_first_d = '0;
            end
          endcase
        end
      end
      bsa_pkg::ST_INIT: begin
        if (ev_vld_q) begin
          we    = 1'b1;
          waddr = ev_w_q;
          wdata = init_word;
          if (ev_w_q == LAST_W) begin
            state_d     = bsa_pkg::ST_IDLE;
            out_vld_d   = 1'b1;
            out_st_d    = 1'b0;
            out_first_d = '0;
          end
        end
      end
      bsa_pkg::ST_ALLOC: begin
        if (ev_vld_q) begin
          prev_free_d = ~rdata_q;
          if (hit) begin
            state_d = bsa_pkg::ST_MARK;
            hit_w_d = ev_w_q;
            hi_d    = {2'b01, hit_b};
            lo_d    = 8'd65 + {2'b00, hit_b} - {1'b0, cmd_q.count};
            used_d  = {rdata_q, ~prev_free_q};
            first_d = bsa_pkg::SLOT_W'({1'b0, ev_w_q, hit_b} + 16'd1 - {9'd0, cmd_q.count});
          end else if (ev_w_q == LAST_W) begin
            state_d     = bsa_pkg::ST_IDLE;
            out_vld_d   = 1'b1;
            out_st_d    = 1'b1;
            out_first_d = '0;
          end
        end
      end
      bsa_pkg::ST_MARK: begin
        we      = 1'b1;
        waddr   = hit_w_q;
        wdata   = used_q[bsa_pkg::EXT_W-1:bsa_pkg::WORD_W] | mask[bsa_pkg::EXT_W-1:bsa_pkg::WORD_W];
        // run reaches back into the previous word
        if (lo_q < 8'd64) begin
          state_d = bsa_pkg::ST_MARK2;
        end else begin
          state_d     = bsa_pkg::ST_IDLE;
          out_vld_d   = 1'b1;
          out_st_d    = 1'b0;
          out_first_d = first_q;
        end
      end
      bsa_pkg::ST_MARK2: begin
        we          = 1'b1;
        waddr       = hit_w_q - 1'b1;
        wdata       = used_q[bsa_pkg::WORD_W-1:0] | mask[bsa_pkg::WORD_W-1:0];
        state_d     = bsa_pkg::ST_IDLE;
        out_vld_d   = 1'b1;
        out_st_d    = 1'b0;
        out_first_d = first_q;
      end
      bsa_pkg::ST_FREE_RD: begin
        re      = 1'b1;
        raddr   = cmd_q.slot[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_W];
        state_d = bsa_pkg::ST_FREE_WR;
      end
      bsa_pkg::ST_FREE_WR: begin
        we    = 1'b1;
        waddr = cmd_q.slot[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_W];
        wdata = rdata_q & ~(64'd1 << cmd_q.slot[bsa_pkg::BIT_W-1:0]);
        state_d     = bsa_pkg::ST_IDLE;
        out_vld_d   = 1'b1;
        out_st_d    = 1'b0;
        out_first_d = '0;
      end
      default: state_d = bsa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bsa_pkg::ST_CLEAR;
      rd_w_q    <= '0;
      rd_more_q <= 1'b0;
      ev_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_w_q    <= rd_w_d;
      rd_more_q <= rd_more_d;
      ev_vld_q  <= ev_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    ev_w_q      <= ev_w_d;
    prev_free_q <= prev_free_d;
    hit_w_q     <= hit_w_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    used_q      <= used_d;
    first_q     <= first_d;
    out_st_q    <= out_st_d;
    out_first_q <= out_first_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign rsp.valid      = out_vld_q;
  assign rsp.status     = out_st_q;
  assign rsp.first_slot = out_first_q;
endmodule
`default_nettype wire

@@ sv/bitmap_slot_allocator.sv @@
// bitmap_slot_allocator: first-fit allocator of contiguous slot runs over a bitmap
// depends on bsa_pkg, the bsa channel interfaces, bsa_front and bsa_back
//
// req carries one request (op, count, slot_index); rsp returns one response
// (status, first_slot) per request, in order. cfg writes free_start (index 0)
// and free_end (index 1); it is always ready. The user must see that it is
// written only while idle; the block does not enforce this. The bitmap lives
// in a 512 x 64 memory with one read and one write port, scanned one word per
// cycle. After reset a clearing pass zeroes the map; req is not ready during
// it. A two-entry queue takes requests while the engine is busy. Free reads
// and rewrites one word, init rewrites every word, allocate scans up to the
// hit and marks one or two words, or scans the whole map on a miss; failing or
// ignored requests are answered straight from idle. The scan of the memory
// sets the throughput: one request at a time. A stalled rsp holds its
// response; the engine waits with the next request until the response is
// taken, while the queue keeps accepting until full.
`default_nettype none
module bitmap_slot_allocator (
  input  wire       clk_i,
  input  wire       rst_ni,
  bsa_req_if.sink   req,
  bsa_rsp_if.source rsp,
  bsa_cfg_if.sink   cfg
);
  logic [bsa_pkg::CFG_W-1:0] free_start_q, free_end_q;
  bsa_pkg::front_out_t       fout;
  bsa_pkg::back_stat_t       stat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_start_q <= '0;
      free_end_q   <= '0;
    end else if (cfg.valid) begin
      case (bsa_pkg::cfg_idx_e'(cfg.index))
        bsa_pkg::CFG_FREE_START: free_start_q <= cfg.data;
        bsa_pkg::CFG_FREE_END:   free_end_q   <= cfg.data;
        default: ;
      endcase
    end
  end

  bsa_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .stat_i (stat),
    .fout_o (fout)
  );

  bsa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fout_i       (fout),
    .free_start_i (free_start_q),
    .free_end_i   (free_end_q),
    .stat_o       (stat),
    .rsp          (rsp)
  );
endmodule
`default_nettype wire
